### rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg: shared types, constants and sign helpers for the range sign tree
// Node layout: node 1 is the root, leaf i sits at node LEAVES+i, node 0 unused.
// ----------------------------------------------------------------------------
package rsp_pkg;

  // Tree geometry
  localparam int LEAVES  = 1024;
  localparam int LVL_W   = $clog2(LEAVES);
  localparam int NODE_W  = LVL_W + 1;        // node address width
  localparam int DEPTH   = 2 * LEAVES;       // node count incl. unused node 0
  localparam int QW      = NODE_W + 1;       // query bounds can reach DEPTH

  // Field widths
  localparam int IDX_W   = 10;
  localparam int VAL_W   = 16;
  localparam int CODE_W  = 2;

  // Sign codes
  localparam logic [CODE_W-1:0] SIGN_POS  = 2'd0;
  localparam logic [CODE_W-1:0] SIGN_NEG  = 2'd1;
  localparam logic [CODE_W-1:0] SIGN_ZERO = 2'd2;

  // Request opcodes
  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Node memory access bundle
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [CODE_W-1:0] wdata;
    logic [NODE_W-1:0] raddr_a;
    logic [NODE_W-1:0] raddr_b;
  } ram_req_t;

  // Product of two sign codes
  function automatic logic [CODE_W-1:0] sign_mul(input logic [CODE_W-1:0] a,
                                                 input logic [CODE_W-1:0] b);
    logic [CODE_W-1:0] r;
    if (a == SIGN_ZERO || b == SIGN_ZERO) begin
      r = SIGN_ZERO;
    end else begin
      r = (a ^ b) & SIGN_NEG;
    end
    return r;
  endfunction

  // Sign code of a two's complement value
  function automatic logic [CODE_W-1:0] sign_of(input logic [VAL_W-1:0] v);
    logic [CODE_W-1:0] r;
    if (v == '0) begin
      r = SIGN_ZERO;
    end else if (v[VAL_W-1]) begin
      r = SIGN_NEG;
    end else begin
      r = SIGN_POS;
    end
    return r;
  endfunction

endpackage

### rtl/range_sign_product_tree.sv
// ----------------------------------------------------------------------------
// range_sign_product_tree: segment tree of element signs with range product
// sign queries over LEAVES elements.
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_ready  cmd, position, new_value,
//                                            range_left, range_right
//   out      response   out_valid/out_ready  sign_code (queries only)
//
// A set writes one node per tree level, leaf to root, through the single
// write port of the node memory. A query issues two node reads per level and
// walks fewer levels for a short range; an empty range skips the walk. After
// reset the node store is cleared, all 2*LEAVES nodes, with in_ready low. One
// request is worked at a time; a finished response sits in the output
// register while the next request is taken, and a later query waits at its
// end if that register is still full.
// ----------------------------------------------------------------------------
module range_sign_product_tree (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic [rsp_pkg::IDX_W-1:0]     position,
  input  logic signed [rsp_pkg::VAL_W-1:0] new_value,
  input  logic [rsp_pkg::IDX_W-1:0]     range_left,
  input  logic [rsp_pkg::IDX_W-1:0]     range_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rsp_pkg::CODE_W-1:0]    sign_code
);

  rsp_pkg::ram_req_t           ram_req;
  logic [rsp_pkg::CODE_W-1:0]  rd_a, rd_b;
  logic                        res_valid, res_ready;
  logic [rsp_pkg::CODE_W-1:0]  res_code;

  rsp_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (in_valid),
    .req_ready   (in_ready),
    .cmd         (cmd),
    .position    (position),
    .new_value   (rsp_pkg::VAL_W'(new_value)),
    .range_left  (range_left),
    .range_right (range_right),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_code    (res_code),
    .ram_req     (ram_req),
    .rd_a        (rd_a),
    .rd_b        (rd_b)
  );

  rsp_node_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // Output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      sign_code <= res_code;
    end
  end

endmodule

### rtl/rsp_node_ram.sv
// ----------------------------------------------------------------------------
// rsp_node_ram: node sign store
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rsp_node_ram (
  input  logic                         clk,
  input  rsp_pkg::ram_req_t            req,
  output logic [rsp_pkg::CODE_W-1:0]   rd_a,
  output logic [rsp_pkg::CODE_W-1:0]   rd_b
);

  logic [rsp_pkg::CODE_W-1:0] mem [rsp_pkg::DEPTH];

  // Write and read ports
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a <= mem[req.raddr_a];
    rd_b <= mem[req.raddr_b];
  end

endmodule

### rtl/rsp_walker.sv
// ----------------------------------------------------------------------------
// rsp_walker: tree walk sequencer
// Clears the store after reset, climbs leaf-to-root on a set, and folds the
// covering nodes of a range level by level on a query.
// ----------------------------------------------------------------------------
module rsp_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          cmd,
  input  logic [rsp_pkg::IDX_W-1:0]     position,
  input  logic [rsp_pkg::VAL_W-1:0]     new_value,
  input  logic [rsp_pkg::IDX_W-1:0]     range_left,
  input  logic [rsp_pkg::IDX_W-1:0]     range_right,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [rsp_pkg::CODE_W-1:0]    res_code,
  output rsp_pkg::ram_req_t             ram_req,
  input  logic [rsp_pkg::CODE_W-1:0]    rd_a,
  input  logic [rsp_pkg::CODE_W-1:0]    rd_b
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SET   = 5'b00100,
    ST_QRY   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                      state, state_next;
  logic [rsp_pkg::NODE_W-1:0]  clr_addr, clr_addr_next;
  logic [rsp_pkg::NODE_W-1:0]  node, node_next;      // parent being rewritten
  logic [rsp_pkg::CODE_W-1:0]  val, val_next;        // new value of its child
  logic [rsp_pkg::QW-1:0]      ql, ql_next;
  logic [rsp_pkg::QW-1:0]      qr, qr_next;
  logic [rsp_pkg::CODE_W-1:0]  acc, acc_next;
  logic                        pend_l, pend_l_next;  // read on port a counts
  logic                        pend_r, pend_r_next;  // read on port b counts

  // Request decode
  logic [31:0]                 right_sat;
  logic [rsp_pkg::NODE_W-1:0]  leaf;
  logic [rsp_pkg::CODE_W-1:0]  parent_val;
  logic [rsp_pkg::CODE_W-1:0]  fold;
  logic [rsp_pkg::QW-1:0]      l_step, r_step;

  assign right_sat = (32'(range_right) >= 32'(rsp_pkg::LEAVES)) ?
                     32'(rsp_pkg::LEAVES - 1) : 32'(range_right);
  assign leaf      = rsp_pkg::NODE_W'(32'(position) + 32'(rsp_pkg::LEAVES));

  assign req_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res_code  = acc;

  // Sequencer
  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    node_next     = node;
    val_next      = val;
    ql_next       = ql;
    qr_next       = qr;
    acc_next      = acc;
    pend_l_next   = 1'b0;
    pend_r_next   = 1'b0;
    ram_req       = '0;
    parent_val    = rsp_pkg::sign_mul(val, rd_a);
    fold          = acc;
    if (pend_l) begin
      fold = rsp_pkg::sign_mul(fold, rd_a);
    end
    if (pend_r) begin
      fold = rsp_pkg::sign_mul(fold, rd_b);
    end
    l_step = ql + rsp_pkg::QW'(ql[0]);
    r_step = qr - rsp_pkg::QW'(qr[0]);

    case (state)
      ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr;
        ram_req.wdata = rsp_pkg::SIGN_ZERO;
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_valid) begin
          if (cmd == rsp_pkg::CMD_SET) begin
            // Write the leaf and fetch its sibling
            if (32'(position) < 32'(rsp_pkg::LEAVES)) begin
              ram_req.we      = 1'b1;
              ram_req.waddr   = leaf;
              ram_req.wdata   = rsp_pkg::sign_of(new_value);
              ram_req.raddr_a = leaf ^ rsp_pkg::NODE_W'(1);
              val_next        = rsp_pkg::sign_of(new_value);
              node_next       = leaf >> 1;
              state_next      = ST_SET;
            end
          end else begin
            acc_next = rsp_pkg::SIGN_POS;
            if (32'(range_left) > right_sat) begin
              state_next = ST_DONE;
            end else begin
              ql_next    = rsp_pkg::QW'(32'(range_left) + 32'(rsp_pkg::LEAVES));
              qr_next    = rsp_pkg::QW'(right_sat + 32'(rsp_pkg::LEAVES) + 32'd1);
              state_next = ST_QRY;
            end
          end
        end
      end

      ST_SET: begin
        // Sibling is in rd_a: rewrite parent, fetch the parent's sibling
        ram_req.we      = 1'b1;
        ram_req.waddr   = node;
        ram_req.wdata   = parent_val;
        ram_req.raddr_a = node ^ rsp_pkg::NODE_W'(1);
        val_next        = parent_val;
        node_next       = node >> 1;
        if (node == rsp_pkg::NODE_W'(1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_QRY: begin
        // Fold last level's reads, then issue this level's boundary reads
        acc_next = fold;
        if (ql < qr) begin
          ram_req.raddr_a = ql[rsp_pkg::NODE_W-1:0];
          ram_req.raddr_b = rsp_pkg::NODE_W'(qr - rsp_pkg::QW'(1));
          pend_l_next     = ql[0];
          pend_r_next     = qr[0];
          ql_next         = l_step >> 1;
          qr_next         = r_step >> 1;
        end else begin
          state_next = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      pend_l   <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend_l   <= pend_l_next;
      pend_r   <= pend_r_next;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    node <= node_next;
    val  <= val_next;
    ql   <= ql_next;
    qr   <= qr_next;
    acc  <= acc_next;
  end

endmodule
